### hdl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Types shared by the first-fit heap allocator and its byte store.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    localparam logic [0:0] REG_HEAP_BASE   = 1'b0;
    localparam logic [0:0] REG_HEAP_LENGTH = 1'b1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [16:0] request_size;
        logic [12:0] align_bytes;
        logic [11:0] align_offset;
        logic [47:0] user_address;
    } req_t;

    typedef struct packed {
        logic [47:0] result_address;
        logic [16:0] block_bytes;
        logic        status;
    } rsp_t;

    typedef struct packed {
        logic        start;
        logic        write;
        logic [63:0] offset;
        logic [63:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] rdata;
    } mem_rsp_t;

endpackage

### hdl/ffa_mem.sv
// ----------------------------------------------------------------------------
// ffa_mem
// Byte store with a 64-bit little-endian access engine, one byte per cycle.
// ----------------------------------------------------------------------------
module ffa_mem #(
    parameter int unsigned HEAP_BYTES = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ffa_pkg::mem_req_t req,
    output ffa_pkg::mem_rsp_t rsp
);

    localparam int unsigned AW = $clog2(HEAP_BYTES);

    logic [7:0]    store_mem [HEAP_BYTES];
    logic          busy_reg;
    logic          done_reg;
    logic [3:0]    cnt_reg;
    logic          wr_reg;
    logic [AW-1:0] idx_reg;
    logic [63:0]   wsh_reg;
    logic [63:0]   rsh_reg;
    logic [7:0]    rd_byte_reg;

    always_ff @(posedge clk)
    begin
        if (busy_reg && !cnt_reg[3])
        begin
            if (wr_reg)
            begin
                store_mem[idx_reg] <= wsh_reg[7:0];
            end
            rd_byte_reg <= store_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            wr_reg  <= req.write;
            idx_reg <= req.offset[AW-1:0];
            wsh_reg <= req.wdata;
        end
        else if (busy_reg)
        begin
            if (!cnt_reg[3])
            begin
                idx_reg <= idx_reg + AW'(1);
                wsh_reg <= {8'h00, wsh_reg[63:8]};
            end
            if (cnt_reg != 4'd0)
            begin
                rsh_reg <= {rd_byte_reg, rsh_reg[63:8]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd8)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy  = busy_reg;
    assign rsp.done  = done_reg;
    assign rsp.rdata = rsh_reg;

endmodule

### hdl/first_fit_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// Boundary-tag first-fit heap allocator over a byte store.
//
// Channel   Direction  Handshake                Payload
// req       in         req_valid / req_stall    ffa_pkg::req_t
// rsp       out        rsp_valid / rsp_stall    ffa_pkg::rsp_t
// apb       in         psel, penable, pready    48-bit base at 0, 17-bit length at 8
//
// Every 64-bit tag access moves one byte per cycle and holds the sequencer until the store reports done.
// One operation is in flight at a time; a finished result waits in the
// output register while the next transfer is taken.
// The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top #(
    parameter int unsigned HEAP_BYTES = 65536
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ffa_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ffa_pkg::rsp_t  rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [63:0]    pwdata,
    output logic [63:0]    prdata,
    output logic           pready
);

    typedef enum logic [21:0] {
        ST_IDLE   = 22'h000001,
        ST_A_CHK  = 22'h000002,
        ST_A_EVAL = 22'h000004,
        ST_A_SPL  = 22'h000008,
        ST_A_TAGU = 22'h000010,
        ST_A_BK0  = 22'h000020,
        ST_A_BK1  = 22'h000040,
        ST_F_BLK  = 22'h000080,
        ST_F_SZ   = 22'h000100,
        ST_F_NXT  = 22'h000200,
        ST_F_NCMP = 22'h000400,
        ST_F_NH   = 22'h000800,
        ST_F_NADD = 22'h001000,
        ST_F_PCMP = 22'h002000,
        ST_F_PREV = 22'h004000,
        ST_F_PH   = 22'h008000,
        ST_F_PADD = 22'h010000,
        ST_Q_SZ   = 22'h020000,
        ST_TAG    = 22'h040000,
        ST_TAGF   = 22'h080000,
        ST_MEM    = 22'h100000,
        ST_DONE   = 22'h200000
    } state_t;

    localparam logic [20:0] HB21 = 21'(HEAP_BYTES);

    state_t       state_reg, state_next, ret_reg, ret_next, tret_reg, tret_next;
    logic [47:0]  base_reg;
    logic [16:0]  length_reg;
    logic [1:0]   op_reg, op_next;
    logic [11:0]  off_reg, off_next;
    logic [14:0]  kadd_reg, kadd_next;
    logic [63:0]  mask_reg, mask_next;
    logic [63:0]  curr_reg, curr_next, end_reg, end_next, need_reg, need_next;
    logic [63:0]  bsize_reg, bsize_next, blk_reg, blk_next, tmp_reg, tmp_next;
    logic [63:0]  tblk_reg, tblk_next, maddr_reg, maddr_next, mwdata_reg, mwdata_next;
    logic [62:0]  tsize_reg, tsize_next;
    logic         tused_reg, tused_next, mwrite_reg, mwrite_next;
    logic         issued_reg, issued_next;
    logic [47:0]  res_addr_reg, res_addr_next;
    logic [16:0]  bytes_reg, bytes_next;
    logic         status_reg, status_next;
    logic         rsp_valid_reg;
    ffa_pkg::rsp_t rsp_reg;

    logic [20:0]  len21;
    logic [12:0]  align13;
    logic [63:0]  ld, rest, sum;
    logic         out_free;
    ffa_pkg::mem_req_t mreq;
    ffa_pkg::mem_rsp_t mrsp;

    ffa_mem #(
        .HEAP_BYTES(HEAP_BYTES)
    ) u_mem (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (mreq),
        .rsp  (mrsp)
    );

    assign mreq.start  = (state_reg == ST_MEM) && !issued_reg && !mrsp.busy && !mrsp.done;
    assign mreq.write  = mwrite_reg;
    assign mreq.offset = maddr_reg - {16'h0000, base_reg};
    assign mreq.wdata  = mwdata_reg;

    assign ld       = mrsp.rdata;
    assign len21    = ({4'h0, length_reg} < HB21) ? {4'h0, length_reg} : HB21;
    assign align13  = (req.align_bytes == 13'd0) ? 13'd1 : req.align_bytes;
    assign rest     = bsize_reg - need_reg;
    assign sum      = bsize_reg + tmp_reg;
    assign out_free = !rsp_valid_reg || !rsp_stall;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[3] == ffa_pkg::REG_HEAP_LENGTH) ? {47'h0, length_reg}
                                                               : {16'h0000, base_reg};

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        tret_next     = tret_reg;
        op_next       = op_reg;
        off_next      = off_reg;
        kadd_next     = kadd_reg;
        mask_next     = mask_reg;
        curr_next     = curr_reg;
        end_next      = end_reg;
        need_next     = need_reg;
        bsize_next    = bsize_reg;
        blk_next      = blk_reg;
        tmp_next      = tmp_reg;
        tblk_next     = tblk_reg;
        tsize_next    = tsize_reg;
        tused_next    = tused_reg;
        maddr_next    = maddr_reg;
        mwdata_next   = mwdata_reg;
        mwrite_next   = mwrite_reg;
        issued_next   = issued_reg;
        res_addr_next = res_addr_reg;
        bytes_next    = bytes_reg;
        status_next   = status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next       = req.opcode;
                    res_addr_next = 48'h0;
                    bytes_next    = 17'h0;
                    status_next   = 1'b0;
                    end_next      = {16'h0000, base_reg} + {43'h0, len21};
                    case (req.opcode)
                        ffa_pkg::OP_INIT:
                        begin
                            if (len21 > 21'd16)
                            begin
                                tblk_next  = {16'h0000, base_reg};
                                tsize_next = {42'h0, len21 - 21'd16};
                                tused_next = 1'b0;
                                tret_next  = ST_DONE;
                                state_next = ST_TAG;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        ffa_pkg::OP_ALLOC:
                        begin
                            off_next   = req.align_offset;
                            kadd_next  = 15'(req.align_offset) + 15'(align13) + 15'd15;
                            mask_next  = ~(64'(align13) - 64'd1);
                            need_next  = 64'(req.request_size) + 64'(align13) + 64'd8;
                            curr_next  = {16'h0000, base_reg};
                            state_next = ST_A_CHK;
                        end
                        default:
                        begin
                            maddr_next  = {16'h0000, req.user_address} - 64'd8;
                            mwrite_next = 1'b0;
                            ret_next    = ST_F_BLK;
                            state_next  = ST_MEM;
                        end
                    endcase
                end
            end
            ST_A_CHK:
            begin
                if (curr_reg < end_reg)
                begin
                    maddr_next  = curr_reg;
                    mwrite_next = 1'b0;
                    ret_next    = ST_A_EVAL;
                    state_next  = ST_MEM;
                end
                else
                begin
                    status_next = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_A_EVAL:
            begin
                bsize_next = {1'b0, ld[62:0]};
                if (!ld[63] && ({1'b0, ld[62:0]} >= need_reg))
                begin
                    state_next = ST_A_SPL;
                end
                else
                begin
                    curr_next  = curr_reg + 64'd16 + {1'b0, ld[62:0]};
                    state_next = ST_A_CHK;
                end
            end
            ST_A_SPL:
            begin
                if (rest <= 64'd16)
                begin
                    need_next  = bsize_reg;
                    state_next = ST_A_TAGU;
                end
                else
                begin
                    tblk_next  = curr_reg + 64'd16 + need_reg;
                    tsize_next = 63'(rest - 64'd16);
                    tused_next = 1'b0;
                    tret_next  = ST_A_TAGU;
                    state_next = ST_TAG;
                end
            end
            ST_A_TAGU:
            begin
                tblk_next  = curr_reg;
                tsize_next = need_reg[62:0];
                tused_next = 1'b1;
                tret_next  = ST_A_BK0;
                state_next = ST_TAG;
            end
            ST_A_BK0:
            begin
                tmp_next   = (curr_reg + 64'(kadd_reg)) & mask_reg;
                state_next = ST_A_BK1;
            end
            ST_A_BK1:
            begin
                res_addr_next = 48'(tmp_reg - 64'(off_reg));
                maddr_next    = tmp_reg - (64'(off_reg) + 64'd8);
                mwdata_next   = curr_reg + 64'd8;
                mwrite_next   = 1'b1;
                ret_next      = ST_DONE;
                state_next    = ST_MEM;
            end
            ST_F_BLK:
            begin
                blk_next    = ld - 64'd8;
                maddr_next  = ld - 64'd8;
                mwrite_next = 1'b0;
                ret_next    = (op_reg == ffa_pkg::OP_QUERY) ? ST_Q_SZ : ST_F_SZ;
                state_next  = ST_MEM;
            end
            ST_F_SZ:
            begin
                bsize_next = {1'b0, ld[62:0]};
                tblk_next  = blk_reg;
                tsize_next = ld[62:0];
                tused_next = 1'b0;
                tret_next  = ST_F_NXT;
                state_next = ST_TAG;
            end
            ST_F_NXT:
            begin
                tmp_next   = blk_reg + 64'd16 + bsize_reg;
                state_next = ST_F_NCMP;
            end
            ST_F_NCMP:
            begin
                if (tmp_reg < end_reg)
                begin
                    maddr_next  = tmp_reg;
                    mwrite_next = 1'b0;
                    ret_next    = ST_F_NH;
                    state_next  = ST_MEM;
                end
                else
                begin
                    state_next = ST_F_PCMP;
                end
            end
            ST_F_NH:
            begin
                tmp_next   = {1'b0, ld[62:0]} + 64'd16;
                state_next = ld[63] ? ST_F_PCMP : ST_F_NADD;
            end
            ST_F_NADD:
            begin
                bsize_next = sum;
                tblk_next  = blk_reg;
                tsize_next = sum[62:0];
                tused_next = 1'b0;
                tret_next  = ST_F_PCMP;
                state_next = ST_TAG;
            end
            ST_F_PCMP:
            begin
                if (blk_reg > {16'h0000, base_reg})
                begin
                    maddr_next  = blk_reg - 64'd8;
                    mwrite_next = 1'b0;
                    ret_next    = ST_F_PREV;
                    state_next  = ST_MEM;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_F_PREV:
            begin
                tblk_next   = ld;
                maddr_next  = ld;
                mwrite_next = 1'b0;
                ret_next    = ST_F_PH;
                state_next  = ST_MEM;
            end
            ST_F_PH:
            begin
                tmp_next   = {1'b0, ld[62:0]} + 64'd16;
                state_next = ld[63] ? ST_DONE : ST_F_PADD;
            end
            ST_F_PADD:
            begin
                bsize_next = sum;
                tsize_next = sum[62:0];
                tused_next = 1'b0;
                tret_next  = ST_DONE;
                state_next = ST_TAG;
            end
            ST_Q_SZ:
            begin
                bytes_next = ld[16:0];
                state_next = ST_DONE;
            end
            ST_TAG:
            begin
                maddr_next  = tblk_reg;
                mwdata_next = {tused_reg, tsize_reg};
                mwrite_next = 1'b1;
                ret_next    = ST_TAGF;
                state_next  = ST_MEM;
            end
            ST_TAGF:
            begin
                maddr_next  = tblk_reg + 64'd8 + {1'b0, tsize_reg};
                mwdata_next = tblk_reg;
                mwrite_next = 1'b1;
                ret_next    = tret_reg;
                state_next  = ST_MEM;
            end
            ST_MEM:
            begin
                if (mreq.start)
                begin
                    issued_next = 1'b1;
                end
                if (mrsp.done)
                begin
                    issued_next = 1'b0;
                    state_next  = ret_reg;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            tret_reg      <= ST_IDLE;
            issued_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            base_reg      <= 48'h0;
            length_reg    <= 17'h10000;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            tret_reg   <= tret_next;
            issued_reg <= issued_next;
            if ((state_reg == ST_DONE) && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[3] == ffa_pkg::REG_HEAP_BASE)
                begin
                    base_reg <= pwdata[47:0];
                end
                else
                begin
                    length_reg <= pwdata[16:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        off_reg      <= off_next;
        kadd_reg     <= kadd_next;
        mask_reg     <= mask_next;
        curr_reg     <= curr_next;
        end_reg      <= end_next;
        need_reg     <= need_next;
        bsize_reg    <= bsize_next;
        blk_reg      <= blk_next;
        tmp_reg      <= tmp_next;
        tblk_reg     <= tblk_next;
        tsize_reg    <= tsize_next;
        tused_reg    <= tused_next;
        maddr_reg    <= maddr_next;
        mwdata_reg   <= mwdata_next;
        mwrite_reg   <= mwrite_next;
        res_addr_reg <= res_addr_next;
        bytes_reg    <= bytes_next;
        status_reg   <= status_next;
        if ((state_reg == ST_DONE) && out_free)
        begin
            rsp_reg.result_address <= res_addr_reg;
            rsp_reg.block_bytes    <= bytes_reg;
            rsp_reg.status         <= status_reg;
        end
    end

endmodule

### hdl/ffa_checker.sv
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks on the heap allocator, attached by a bind statement.
// ----------------------------------------------------------------------------
module ffa_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input ffa_pkg::rsp_t rsp,
    input logic          pready
);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("A second transfer was taken while an operation was running.");

    a_fail_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status) |-> (rsp.result_address == 48'h0 && rsp.block_bytes == 17'h0))
        else $error("A failed allocation carries a non-zero result.");

    a_rsp_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("A stalled result transfer changed.");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("The configuration port inserted a wait state.");

endmodule

bind first_fit_heap_allocator_top ffa_checker u_ffa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .pready   (pready)
);

### tb/tb_first_fit_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator_top
// Self-checking testbench for the first-fit heap allocator.
//
// Each request is run through a behavioural copy of the boundary-tag heap
// when it is generated. Frees and queries only use addresses that a live
// allocation returned. The expected responses are then compared in order
// with every response transfer. The run first goes through a set of corner
// cases under the reset configuration. It then goes through several
// base/length settings with random traffic, and random gaps on both
// channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator_top;

    localparam int unsigned STORE_BYTES = 65536;
    localparam int unsigned IDLE_LIMIT  = 20000;
    localparam logic [63:0] USED_FLAG   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] SIZE_BITS   = 64'h7FFF_FFFF_FFFF_FFFF;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    ffa_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_stall;
    ffa_pkg::rsp_t rsp;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [3:0]    paddr;
    logic [63:0]   pwdata;
    logic [63:0]   prdata;
    logic          pready;

    first_fit_heap_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Behavioural heap state.
    logic [7:0]  heap_bytes [STORE_BYTES];
    logic [47:0] cur_base;
    logic [16:0] cur_length;

    ffa_pkg::req_t pending_reqs [$];
    ffa_pkg::rsp_t expected_rsps [$];
    logic [47:0]   live_ptrs [$];
    int            fail_count;
    int            idle_cycles;
    bit            quiet_in;
    bit            quiet_out;
    int            in_gap;
    int            out_gap;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [15:0] byte_index(logic [63:0] a);
        return 16'(a - 64'(cur_base));
    endfunction

    function automatic logic [63:0] read_tag(logic [63:0] a);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < 8; i++)
            v |= 64'(heap_bytes[byte_index(a + 64'(i))]) << (8 * i);
        return v;
    endfunction

    function automatic void write_tag(logic [63:0] a, logic [63:0] v);
        for (int i = 0; i < 8; i++)
            heap_bytes[byte_index(a + 64'(i))] = v[8*i +: 8];
    endfunction

    function automatic void mark_block(logic [63:0] blk, logic [63:0] size, bit used);
        logic [63:0] s;
        s = size & SIZE_BITS;
        write_tag(blk, s | (used ? USED_FLAG : 64'd0));
        write_tag(blk + 64'd8 + s, blk);
    endfunction

    function automatic ffa_pkg::rsp_t heap_apply(ffa_pkg::req_t r);
        ffa_pkg::rsp_t o;
        logic [63:0]   span;
        logic [63:0]   limit;
        logic [63:0]   align;
        logic [63:0]   need;
        logic [63:0]   curr;
        logic [63:0]   bsize;
        logic [63:0]   h;
        logic [63:0]   rest;
        logic [63:0]   payload;
        logic [63:0]   aligned;
        logic [63:0]   blk;
        logic [63:0]   nxt;
        logic [63:0]   prv;
        bit            found;
        o = '0;
        span = (cur_length < STORE_BYTES) ? 64'(cur_length) : 64'(STORE_BYTES);
        limit = 64'(cur_base) + span;
        case (r.opcode)
            ffa_pkg::OP_INIT:
            begin
                if (span > 64'd16)
                    mark_block(64'(cur_base), span - 64'd16, 1'b0);
            end
            ffa_pkg::OP_ALLOC:
            begin
                align = (r.align_bytes == 0) ? 64'd1 : 64'(r.align_bytes);
                need = 64'(r.request_size) + align + 64'd8;
                curr = 64'(cur_base);
                bsize = '0;
                found = 1'b0;
                while (curr < limit && !found)
                begin
                    h = read_tag(curr);
                    bsize = h & SIZE_BITS;
                    if (!h[63] && bsize >= need)
                        found = 1'b1;
                    else
                        curr += 64'd16 + bsize;
                end
                if (found)
                begin
                    rest = bsize - need;
                    if (rest <= 64'd16)
                        need = bsize;
                    else
                        mark_block(curr + 64'd16 + need, rest - 64'd16, 1'b0);
                    mark_block(curr, need, 1'b1);
                    payload = curr + 64'd8;
                    aligned = (payload + 64'(r.align_offset) + 64'd8 + align - 64'd1)
                              & ~(align - 64'd1);
                    aligned -= 64'(r.align_offset);
                    write_tag(aligned - 64'd8, payload);
                    o.result_address = aligned[47:0];
                end
                else
                begin
                    o.status = 1'b1;
                end
            end
            ffa_pkg::OP_FREE:
            begin
                blk = read_tag(64'(r.user_address) - 64'd8) - 64'd8;
                bsize = read_tag(blk) & SIZE_BITS;
                mark_block(blk, bsize, 1'b0);
                nxt = blk + 64'd16 + bsize;
                if (nxt < limit)
                begin
                    h = read_tag(nxt);
                    if (!h[63])
                    begin
                        bsize += (h & SIZE_BITS) + 64'd16;
                        mark_block(blk, bsize, 1'b0);
                    end
                end
                if (blk > 64'(cur_base))
                begin
                    prv = read_tag(blk - 64'd8);
                    h = read_tag(prv);
                    if (!h[63])
                    begin
                        bsize += (h & SIZE_BITS) + 64'd16;
                        mark_block(prv, bsize, 1'b0);
                    end
                end
            end
            default:
            begin
                blk = read_tag(64'(r.user_address) - 64'd8) - 64'd8;
                o.block_bytes = 17'(read_tag(blk) & SIZE_BITS);
            end
        endcase
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic queue_request(ffa_pkg::req_t r);
        ffa_pkg::rsp_t o;
        o = heap_apply(r);
        if (r.opcode == ffa_pkg::OP_INIT)
            live_ptrs.delete();
        if (r.opcode == ffa_pkg::OP_ALLOC && !o.status)
            live_ptrs.push_back(o.result_address);
        pending_reqs.push_back(r);
        expected_rsps.push_back(o);
    endtask

    task automatic queue_op(logic [1:0] op, int unsigned rsize, int unsigned abytes,
                            int unsigned aoff, logic [47:0] uaddr);
        ffa_pkg::req_t r;
        r.opcode       = op;
        r.request_size = 17'(rsize);
        r.align_bytes  = 13'(abytes);
        r.align_offset = 12'(aoff);
        r.user_address = uaddr;
        queue_request(r);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == ffa_pkg::REG_HEAP_BASE)
            cur_base = value[47:0];
        else
            cur_length = value[16:0];
    endtask

    task automatic random_traffic(int count);
        int          r;
        int          k;
        int unsigned rsize;
        int unsigned abytes;
        int unsigned aoff;
        logic [47:0] p;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
            begin
                queue_op(ffa_pkg::OP_INIT, $urandom, $urandom, $urandom,
                         48'({$urandom, $urandom}));
            end
            else if (r < 50 || live_ptrs.size() == 0)
            begin
                k = $urandom_range(0, 99);
                if (k < 80)
                    rsize = $urandom_range(0, 256);
                else if (k < 95)
                    rsize = $urandom_range(257, 4096);
                else
                    rsize = $urandom_range(4097, 65536);
                k = $urandom_range(0, 99);
                if (k < 85)
                    abytes = 1 << $urandom_range(0, 12);
                else if (k < 90)
                    abytes = 0;
                else
                    abytes = $urandom_range(1, 4096);
                aoff = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                   : $urandom_range(0, 64);
                queue_op(ffa_pkg::OP_ALLOC, rsize, abytes, aoff, 48'({$urandom, $urandom}));
            end
            else if (r < 80)
            begin
                k = $urandom_range(0, live_ptrs.size() - 1);
                p = live_ptrs[k];
                live_ptrs.delete(k);
                queue_op(ffa_pkg::OP_FREE, $urandom, $urandom, $urandom, p);
            end
            else
            begin
                p = live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
                queue_op(ffa_pkg::OP_QUERY, $urandom, $urandom, $urandom, p);
            end
        end
    endtask

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            in_gap    <= 0;
            quiet_in  <= 1'b0;
        end
        else if (!req_valid || !req_stall)
        begin
            if ($urandom_range(0, 63) == 0)
                quiet_in <= ~quiet_in;
            if (in_gap > 0)
            begin
                in_gap    <= in_gap - 1;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                req       <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                in_gap    <= quiet_in ? 0 : pick_gap();
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Response monitor and stall generator.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            out_gap   <= 0;
            quiet_out <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected response transfer: result_address %h",
                           rsp.result_address);
                    fail_count++;
                end
                else
                begin
                    if (rsp.result_address !== expected_rsps[0].result_address)
                    begin
                        $error("result_address: expected %h, actual %h",
                               expected_rsps[0].result_address, rsp.result_address);
                        fail_count++;
                    end
                    if (rsp.block_bytes !== expected_rsps[0].block_bytes)
                    begin
                        $error("block_bytes: expected %0d, actual %0d",
                               expected_rsps[0].block_bytes, rsp.block_bytes);
                        fail_count++;
                    end
                    if (rsp.status !== expected_rsps[0].status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               expected_rsps[0].status, rsp.status);
                        fail_count++;
                    end
                    void'(expected_rsps.pop_front());
                end
            end
            if ($urandom_range(0, 63) == 0)
                quiet_out <= ~quiet_out;
            if (out_gap > 0)
            begin
                out_gap   <= out_gap - 1;
                rsp_stall <= 1'b1;
            end
            else
            begin
                out_gap   <= quiet_out ? 0 : pick_gap();
                rsp_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [47:0] a;
        logic [47:0] b;
        logic [47:0] c;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        fail_count = 0;
        cur_base   = '0;
        cur_length = 17'd65536;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Corner cases under the reset configuration.
        queue_op(ffa_pkg::OP_INIT, 0, 1, 0, '0);
        queue_op(ffa_pkg::OP_ALLOC, 0, 1, 0, '0);
        a = live_ptrs[0];
        queue_op(ffa_pkg::OP_ALLOC, 100, 4096, 4095, '1);
        b = live_ptrs[1];
        queue_op(ffa_pkg::OP_ALLOC, 40, 0, 0, '0);
        queue_op(ffa_pkg::OP_ALLOC, 77, 3, 5, '0);
        queue_op(ffa_pkg::OP_ALLOC, 30, 8, 0, '0);
        c = live_ptrs[4];
        queue_op(ffa_pkg::OP_ALLOC, 65536, 4096, 0, '0);
        queue_op(ffa_pkg::OP_QUERY, 0, 1, 0, a);
        queue_op(ffa_pkg::OP_QUERY, 0, 1, 0, b);
        queue_op(ffa_pkg::OP_QUERY, 0, 1, 0, c);
        queue_op(ffa_pkg::OP_FREE, 0, 1, 0, b);
        queue_op(ffa_pkg::OP_FREE, 0, 1, 0, a);
        queue_op(ffa_pkg::OP_FREE, 0, 1, 0, live_ptrs[3]);
        queue_op(ffa_pkg::OP_FREE, 0, 1, 0, live_ptrs[2]);
        queue_op(ffa_pkg::OP_FREE, 0, 1, 0, c);
        queue_op(ffa_pkg::OP_ALLOC, 65536 - 4096 - 40, 4096, 0, '0);
        queue_op(ffa_pkg::OP_QUERY, 0, 1, 0, live_ptrs[live_ptrs.size() - 1]);
        live_ptrs.delete();
        random_traffic(150);
        wait_idle();

        // Region at the top of the address space, with the shortest length.
        write_reg(ffa_pkg::REG_HEAP_BASE, 64'hFFFF_FFFF_FFF0);
        write_reg(ffa_pkg::REG_HEAP_LENGTH, 64'd17);
        queue_op(ffa_pkg::OP_INIT, 0, 1, 0, '0);
        queue_op(ffa_pkg::OP_ALLOC, 0, 1, 0, '0);
        queue_op(ffa_pkg::OP_ALLOC, 0, 0, 0, '0);
        random_traffic(30);
        wait_idle();

        write_reg(ffa_pkg::REG_HEAP_LENGTH, 64'd4096);
        queue_op(ffa_pkg::OP_INIT, 0, 1, 0, '0);
        random_traffic(150);
        wait_idle();

        write_reg(ffa_pkg::REG_HEAP_BASE, {16'd0, $urandom, 16'd0} & 64'hFFFF_FFFF_FFFF);
        write_reg(ffa_pkg::REG_HEAP_LENGTH, 64'd65536);
        queue_op(ffa_pkg::OP_INIT, 0, 1, 0, '0);
        random_traffic(200);
        wait_idle();

        write_reg(ffa_pkg::REG_HEAP_BASE, 64'd0);
        write_reg(ffa_pkg::REG_HEAP_LENGTH, 64'(17'($urandom_range(64, 30000))));
        queue_op(ffa_pkg::OP_INIT, 0, 1, 0, '0);
        random_traffic(30);
        wait_idle();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
